FILE: hw/rtl/mfdc_pkg.sv
// ----------------------------------------------------------------------------
// mfdc_pkg
// Shared types and codes of the mesh face delete compactor.
// ----------------------------------------------------------------------------
package mfdc_pkg;

    localparam int KIND_W  = 2;
    localparam int COUNT_W = 8;
    localparam int VID_W   = 12;
    localparam int VT_W    = 13;
    localparam int VAL_W   = 12;

    localparam logic [KIND_W-1:0] KIND_HEAD   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ID     = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FINISH = 2'd2;
    localparam logic [KIND_W-1:0] KIND_DRAIN  = 2'd3;

    localparam logic [KIND_W-1:0] OUT_COUNT = 2'd0;
    localparam logic [KIND_W-1:0] OUT_ID    = 2'd1;
    localparam logic [KIND_W-1:0] OUT_OLD   = 2'd2;
    localparam logic [KIND_W-1:0] OUT_NONE  = 2'd3;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [COUNT_W-1:0] count;
        logic               del;
        logic [VID_W-1:0]   id;
    } cmd_t;

    typedef struct packed {
        logic ready;
        logic clearing;
    } bstat_t;

endpackage

FILE: hw/rtl/mfdc_front.sv
// ----------------------------------------------------------------------------
// mfdc_front
// Command intake: captures words into a two-entry queue toward the back end.
// ----------------------------------------------------------------------------
module mfdc_front
    import mfdc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [KIND_W-1:0]  kind,
    input  logic [COUNT_W-1:0] face_vertex_count,
    input  logic               delete_flag,
    input  logic [VID_W-1:0]   vertex_id,
    input  bstat_t             bstat,
    output logic               cmd_valid,
    output cmd_t               cmd
);

    cmd_t       q_reg [2];
    logic       wp_reg, wp_next;
    logic       rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push, pop;

    assign busy      = (cnt_reg == 2'd2) | bstat.clearing;
    assign push      = start & ~busy;
    assign cmd_valid = (cnt_reg != 2'd0);
    assign pop       = cmd_valid & bstat.ready;
    assign cmd       = q_reg[rp_reg];

    always_comb
    begin
        wp_next  = push ? ~wp_reg : wp_reg;
        rp_next  = pop ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wp_reg] <= '{kind: kind, count: face_vertex_count,
                               del: delete_flag, id: vertex_id};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

FILE: hw/rtl/mfdc_back.sv
// ----------------------------------------------------------------------------
// mfdc_back
// Executes words: stores kept faces, walks the used map, drains results.
// ----------------------------------------------------------------------------
module mfdc_back
    import mfdc_pkg::*;
#(
    parameter int MAX_VERTICES  = 4096,
    parameter int MAX_FACES     = 1024,
    parameter int MAX_CORNERS   = 4096,
    parameter int MAX_FACE_SIZE = 255
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    input  cmd_t               cmd,
    output bstat_t             bstat,
    input  logic               cfg_valid,
    input  logic [VT_W-1:0]    cfg_data,
    output logic               result_valid,
    output logic [KIND_W-1:0]  out_kind,
    output logic [VAL_W-1:0]   out_value,
    output logic               last,
    output logic               error
);

    localparam int VAW = $clog2(MAX_VERTICES);
    localparam int FAW = $clog2(MAX_FACES);
    localparam int CAW = $clog2(MAX_CORNERS);
    localparam int NW  = $clog2(MAX_VERTICES + 1);
    localparam int FTW = $clog2(MAX_FACES + 1);
    localparam int CTW = $clog2(MAX_CORNERS + 1);
    localparam int PW  = $clog2(MAX_FACES + MAX_CORNERS + MAX_VERTICES + 1);
    localparam logic [VAW-1:0] IDX_LAST = VAW'(MAX_VERTICES - 1);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_WALK  = 3'd2;
    localparam logic [2:0] S_WEND  = 3'd3;
    localparam logic [2:0] S_DR1   = 3'd4;
    localparam logic [2:0] S_DR2   = 3'd5;

    logic               used_mem  [MAX_VERTICES];
    logic [VAL_W-1:0]   remap_mem [MAX_VERTICES];
    logic [VAW-1:0]     surv_mem  [MAX_VERTICES];
    logic [COUNT_W-1:0] face_mem  [MAX_FACES];
    logic [VID_W-1:0]   id_mem    [MAX_CORNERS];

    logic               used_rd_reg;
    logic [VAL_W-1:0]   remap_rd_reg;
    logic [VAW-1:0]     surv_rd_reg;
    logic [COUNT_W-1:0] face_rd_reg;
    logic [VID_W-1:0]   id_rd_reg;

    logic [2:0]         state_reg, state_next;
    logic [VAW-1:0]     idx_reg, idx_next;
    logic [NW-1:0]      n_reg, n_next;
    logic               wv_reg, wv_next;
    logic [VAW-1:0]     widx_reg, widx_next;
    logic [FTW-1:0]     kft_reg, kft_next;
    logic [CTW-1:0]     kit_reg, kit_next;
    logic [NW-1:0]      st_reg, st_next;
    logic [COUNT_W-1:0] cl_reg, cl_next;
    logic               fd_reg, fd_next;
    logic               dr_reg, dr_next;
    logic [PW-1:0]      ptr_reg, ptr_next;
    logic               err_reg, err_next;
    logic [VT_W-1:0]    vt_reg, vt_next;
    logic [1:0]         sel_reg, sel_next;
    logic               lst_reg, lst_next;
    logic               rv_reg, rv_next;
    logic [KIND_W-1:0]  ok_reg, ok_next;
    logic [VAL_W-1:0]   ov_reg, ov_next;
    logic               ol_reg, ol_next;
    logic               oe_reg, oe_next;

    logic               used_we, used_wd, used_re;
    logic [VAW-1:0]     used_wa, used_ra;
    logic               remap_we, remap_re;
    logic [VAW-1:0]     remap_wa, remap_ra;
    logic               surv_we, surv_re;
    logic [VAW-1:0]     surv_wa, surv_ra;
    logic               face_we, face_re;
    logic [FAW-1:0]     face_wa, face_ra;
    logic               id_we, id_re;
    logic [CAW-1:0]     id_wa, id_ra;

    logic [PW-1:0]      tot, pn, idoff, svoff;
    logic               drop;

    assign bstat.ready    = (state_reg == S_IDLE);
    assign bstat.clearing = (state_reg == S_CLEAR);
    assign result_valid   = rv_reg;
    assign out_kind       = ok_reg;
    assign out_value      = ov_reg;
    assign last           = ol_reg;
    assign error          = oe_reg;

    assign tot   = PW'(kft_reg) + PW'(kit_reg) + PW'(st_reg);
    assign pn    = ptr_reg + PW'(1);
    assign idoff = ptr_reg - PW'(kft_reg);
    assign svoff = ptr_reg - PW'(kft_reg) - PW'(kit_reg);

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        n_next     = n_reg;
        wv_next    = wv_reg;
        widx_next  = widx_reg;
        kft_next   = kft_reg;
        kit_next   = kit_reg;
        st_next    = st_reg;
        cl_next    = cl_reg;
        fd_next    = fd_reg;
        dr_next    = dr_reg;
        ptr_next   = ptr_reg;
        err_next   = err_reg;
        vt_next    = cfg_valid ? cfg_data : vt_reg;
        sel_next   = sel_reg;
        lst_next   = lst_reg;
        rv_next    = 1'b0;
        ok_next    = ok_reg;
        ov_next    = ov_reg;
        ol_next    = ol_reg;
        oe_next    = oe_reg;
        drop       = 1'b0;
        used_we = 1'b0; used_wd = 1'b0; used_wa = '0; used_re = 1'b0; used_ra = '0;
        remap_we = 1'b0; remap_wa = '0; remap_re = 1'b0; remap_ra = '0;
        surv_we = 1'b0; surv_wa = '0; surv_re = 1'b0; surv_ra = '0;
        face_we = 1'b0; face_wa = '0; face_re = 1'b0; face_ra = '0;
        id_we = 1'b0; id_wa = '0; id_re = 1'b0; id_ra = '0;

        // retire the previous walk entry
        if ((state_reg == S_WALK || state_reg == S_WEND) && wv_reg && used_rd_reg
            && (32'(widx_reg) < 32'(vt_reg)))
        begin
            remap_we = 1'b1;
            remap_wa = widx_reg;
            surv_we  = 1'b1;
            surv_wa  = VAW'(n_reg);
            n_next   = n_reg + NW'(1);
        end
        remap_ra = VAW'(id_rd_reg);

        case (state_reg)
            S_CLEAR:
            begin
                used_we  = 1'b1;
                used_wa  = idx_reg;
                idx_next = idx_reg + VAW'(1);
                if (idx_reg == IDX_LAST)
                begin
                    idx_next   = '0;
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    case (cmd.kind)
                        KIND_DRAIN:
                        begin
                            if (!dr_reg)
                            begin
                                rv_next = 1'b1; ok_next = OUT_NONE; ov_next = '0;
                                ol_next = 1'b0; oe_next = err_reg;
                            end
                            else if (ptr_reg >= tot)
                            begin
                                rv_next = 1'b1; ok_next = OUT_NONE; ov_next = '0;
                                ol_next = 1'b1; oe_next = err_reg;
                                kft_next = '0; kit_next = '0; st_next = '0; cl_next = '0;
                                fd_next = 1'b0; dr_next = 1'b0; ptr_next = '0;
                            end
                            else
                            begin
                                if (ptr_reg < PW'(kft_reg))
                                begin
                                    face_re  = 1'b1;
                                    face_ra  = ptr_reg[FAW-1:0];
                                    sel_next = OUT_COUNT;
                                end
                                else if (ptr_reg < PW'(kft_reg) + PW'(kit_reg))
                                begin
                                    id_re    = 1'b1;
                                    id_ra    = idoff[CAW-1:0];
                                    sel_next = OUT_ID;
                                end
                                else
                                begin
                                    surv_re  = 1'b1;
                                    surv_ra  = svoff[VAW-1:0];
                                    sel_next = OUT_OLD;
                                end
                                ptr_next   = pn;
                                lst_next   = (pn >= tot);
                                state_next = S_DR1;
                                if (pn >= tot)
                                begin
                                    kft_next = '0; kit_next = '0; st_next = '0; cl_next = '0;
                                    fd_next = 1'b0; dr_next = 1'b0; ptr_next = '0;
                                end
                            end
                        end
                        KIND_HEAD:
                        begin
                            if (!dr_reg)
                            begin
                                cl_next = cmd.count;
                                drop    = cmd.del;
                                if (32'(cmd.count) > MAX_FACE_SIZE)
                                begin
                                    err_next = 1'b1;
                                    drop     = 1'b1;
                                end
                                if (!drop)
                                begin
                                    if (32'(kft_reg) >= MAX_FACES)
                                    begin
                                        err_next = 1'b1;
                                        drop     = 1'b1;
                                    end
                                    else
                                    begin
                                        face_we  = 1'b1;
                                        face_wa  = FAW'(kft_reg);
                                        kft_next = kft_reg + FTW'(1);
                                    end
                                end
                                fd_next = drop;
                            end
                        end
                        KIND_ID:
                        begin
                            if (!dr_reg && cl_reg != '0)
                            begin
                                cl_next = cl_reg - COUNT_W'(1);
                                if (!fd_reg)
                                begin
                                    if (32'(cmd.id) >= 32'(vt_reg)
                                        || 32'(cmd.id) >= MAX_VERTICES)
                                    begin
                                        err_next = 1'b1;
                                    end
                                    else if (32'(kit_reg) >= MAX_CORNERS)
                                    begin
                                        err_next = 1'b1;
                                    end
                                    else
                                    begin
                                        id_we    = 1'b1;
                                        id_wa    = CAW'(kit_reg);
                                        kit_next = kit_reg + CTW'(1);
                                        used_we  = 1'b1;
                                        used_wd  = 1'b1;
                                        used_wa  = VAW'(cmd.id);
                                    end
                                end
                            end
                        end
                        KIND_FINISH:
                        begin
                            if (!dr_reg)
                            begin
                                idx_next   = '0;
                                n_next     = '0;
                                wv_next    = 1'b0;
                                state_next = S_WALK;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_WALK:
            begin
                used_re   = 1'b1;
                used_ra   = idx_reg;
                used_we   = 1'b1;
                used_wa   = idx_reg;
                wv_next   = 1'b1;
                widx_next = idx_reg;
                idx_next  = idx_reg + VAW'(1);
                if (idx_reg == IDX_LAST)
                begin
                    idx_next   = '0;
                    state_next = S_WEND;
                end
            end
            S_WEND:
            begin
                st_next    = n_next;
                dr_next    = 1'b1;
                ptr_next   = '0;
                cl_next    = '0;
                fd_next    = 1'b0;
                wv_next    = 1'b0;
                state_next = S_IDLE;
            end
            S_DR1:
            begin
                case (sel_reg)
                    OUT_COUNT:
                    begin
                        rv_next = 1'b1; ok_next = OUT_COUNT; ov_next = VAL_W'(face_rd_reg);
                        ol_next = lst_reg; oe_next = err_reg; state_next = S_IDLE;
                    end
                    OUT_OLD:
                    begin
                        rv_next = 1'b1; ok_next = OUT_OLD; ov_next = VAL_W'(surv_rd_reg);
                        ol_next = lst_reg; oe_next = err_reg; state_next = S_IDLE;
                    end
                    default:
                    begin
                        remap_re   = 1'b1;
                        state_next = S_DR2;
                    end
                endcase
            end
            S_DR2:
            begin
                rv_next = 1'b1; ok_next = OUT_ID; ov_next = remap_rd_reg;
                ol_next = lst_reg; oe_next = err_reg; state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (used_re)
        begin
            used_rd_reg <= used_mem[used_ra];
        end
        if (used_we)
        begin
            used_mem[used_wa] <= used_wd;
        end
    end

    always_ff @(posedge clk)
    begin
        if (remap_re)
        begin
            remap_rd_reg <= remap_mem[remap_ra];
        end
        if (remap_we)
        begin
            remap_mem[remap_wa] <= VAL_W'(n_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (surv_re)
        begin
            surv_rd_reg <= surv_mem[surv_ra];
        end
        if (surv_we)
        begin
            surv_mem[surv_wa] <= widx_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (face_re)
        begin
            face_rd_reg <= face_mem[face_ra];
        end
        if (face_we)
        begin
            face_mem[face_wa] <= cmd.count;
        end
    end

    always_ff @(posedge clk)
    begin
        if (id_re)
        begin
            id_rd_reg <= id_mem[id_ra];
        end
        if (id_we)
        begin
            id_mem[id_wa] <= cmd.id;
        end
    end

    always_ff @(posedge clk)
    begin
        widx_reg <= widx_next;
        sel_reg  <= sel_next;
        lst_reg  <= lst_next;
        ok_reg   <= ok_next;
        ov_reg   <= ov_next;
        ol_reg   <= ol_next;
        oe_reg   <= oe_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            idx_reg   <= '0;
            n_reg     <= '0;
            wv_reg    <= 1'b0;
            kft_reg   <= '0;
            kit_reg   <= '0;
            st_reg    <= '0;
            cl_reg    <= '0;
            fd_reg    <= 1'b0;
            dr_reg    <= 1'b0;
            ptr_reg   <= '0;
            err_reg   <= 1'b0;
            vt_reg    <= '0;
            rv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            n_reg     <= n_next;
            wv_reg    <= wv_next;
            kft_reg   <= kft_next;
            kit_reg   <= kit_next;
            st_reg    <= st_next;
            cl_reg    <= cl_next;
            fd_reg    <= fd_next;
            dr_reg    <= dr_next;
            ptr_reg   <= ptr_next;
            err_reg   <= err_next;
            vt_reg    <= vt_next;
            rv_reg    <= rv_next;
        end
    end

endmodule

FILE: hw/rtl/mesh_face_delete_compactor_unit.sv
// ----------------------------------------------------------------------------
// mesh_face_delete_compactor_unit
// Deletes flagged faces of a streamed mesh and renumbers surviving vertices.
// ----------------------------------------------------------------------------
// Words enter on start while busy is low and queue two deep in front of the
// executor. A drain word that returns a remapped id needs two dependent
// memory reads, and a drain during loading answers with an empty result.
// Finish walks the whole used map, one entry a cycle. After reset a clearing
// pass over the whole used map holds busy high. Results appear for one cycle
// with result_valid and cannot be stalled; error repeats an internal flag
// that is sticky until reset, and it is refreshed with each result.
module mesh_face_delete_compactor_unit
    import mfdc_pkg::*;
#(
    parameter int MAX_VERTICES  = 4096,
    parameter int MAX_FACES     = 1024,
    parameter int MAX_CORNERS   = 4096,
    parameter int MAX_FACE_SIZE = 255
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [KIND_W-1:0]  kind,
    input  logic [COUNT_W-1:0] face_vertex_count,
    input  logic               delete_flag,
    input  logic [VID_W-1:0]   vertex_id,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [VT_W-1:0]    cfg_data,
    output logic               result_valid,
    output logic [KIND_W-1:0]  out_kind,
    output logic [VAL_W-1:0]   out_value,
    output logic               last,
    output logic               error
);

    bstat_t bstat;
    logic   cmd_valid;
    cmd_t   cmd;

    assign cfg_ready = 1'b1;

    mfdc_front u_front (
        .clk               (clk),
        .rst_n             (rst_n),
        .start             (start),
        .busy              (busy),
        .kind              (kind),
        .face_vertex_count (face_vertex_count),
        .delete_flag       (delete_flag),
        .vertex_id         (vertex_id),
        .bstat             (bstat),
        .cmd_valid         (cmd_valid),
        .cmd               (cmd)
    );

    mfdc_back #(
        .MAX_VERTICES  (MAX_VERTICES),
        .MAX_FACES     (MAX_FACES),
        .MAX_CORNERS   (MAX_CORNERS),
        .MAX_FACE_SIZE (MAX_FACE_SIZE)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (cmd_valid),
        .cmd          (cmd),
        .bstat        (bstat),
        .cfg_valid    (cfg_valid),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .out_kind     (out_kind),
        .out_value    (out_value),
        .last         (last),
        .error        (error)
    );

endmodule

FILE: hw/rtl/mfdc_checker.sv
// ----------------------------------------------------------------------------
// mfdc_checker
// Port-level checks of the mesh face delete compactor.
// ----------------------------------------------------------------------------
module mfdc_checker
    import mfdc_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               busy,
    input logic               result_valid,
    input logic [KIND_W-1:0]  out_kind,
    input logic [VAL_W-1:0]   out_value,
    input logic               error
);

    a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && out_kind == OUT_NONE |-> out_value == '0)
        else $error("empty result carries a value");

    a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        error |=> error)
        else $error("error flag dropped");

    a_clear_busy: assert property (@(posedge clk)
        $past(!rst_n) |-> busy)
        else $error("accepting during clearing pass");

    a_no_rst_res: assert property (@(posedge clk)
        $past(!rst_n) |-> !result_valid)
        else $error("result right after reset");

endmodule

bind mesh_face_delete_compactor_unit mfdc_checker u_chk (.*);
